### rtl/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// lsfs_pkg
// Shared constants, request codes and types of the LED strip frame sender.
// ----------------------------------------------------------------------------
package lsfs_pkg;

  localparam int MAX_LEDS_DEF = 256;

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 8;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 9;
  localparam int TAIL_W = 5;

  localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BLANK = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd4;

  localparam logic [WORD_W-1:0] OFF_WORD   = 32'hE000_0000;
  localparam logic [BYTE_W-1:0] BRIGHT_MIN = 8'd32;
  localparam logic [BYTE_W-1:0] BRIGHT_ADD = 8'd224;

  typedef struct packed {
    logic              wr_en;
    logic              clr;
    logic              rd_en;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } store_req_t;

  function automatic int store_depth(input int max_leds);
    store_depth = (max_leds < (1 << IDX_W)) ? max_leds : (1 << IDX_W);
  endfunction

endpackage

### rtl/lsfs_if.sv
// ----------------------------------------------------------------------------
// lsfs_req_if / lsfs_tx_if
// Valid/ready channels for requests into and bytes out of the frame sender.
// ----------------------------------------------------------------------------
interface lsfs_req_if;
  logic                             valid;
  logic                             ready;
  logic [lsfs_pkg::REQ_W-1:0]  req_type;
  logic [lsfs_pkg::IDX_W-1:0]  led_index;
  logic [lsfs_pkg::BYTE_W-1:0] brightness_in;
  logic [lsfs_pkg::BYTE_W-1:0] blue_in;
  logic [lsfs_pkg::BYTE_W-1:0] green_in;
  logic [lsfs_pkg::BYTE_W-1:0] red_in;

  modport source (output valid, req_type, led_index, brightness_in, blue_in, green_in,
                  red_in, input ready);
  modport sink (input valid, req_type, led_index, brightness_in, blue_in, green_in,
                red_in, output ready);
endinterface

interface lsfs_tx_if;
  logic                             valid;
  logic                             ready;
  logic [lsfs_pkg::BYTE_W-1:0] out_byte;
  logic                             select_begin;
  logic                             select_end;
  logic                             last;

  modport source (output valid, out_byte, select_begin, select_end, last, input ready);
  modport sink (input valid, out_byte, select_begin, select_end, last, output ready);
endinterface

### rtl/lsfs_store.sv
// ----------------------------------------------------------------------------
// lsfs_store
// Per-LED word memory with registered read and written flags.
// ----------------------------------------------------------------------------
module lsfs_store #(
  parameter int MAX_LEDS = lsfs_pkg::MAX_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lsfs_pkg::store_req_t          sreq,
  output logic [lsfs_pkg::WORD_W-1:0]   rd_data,
  output logic                          rd_valid
);

  localparam int DEPTH = lsfs_pkg::store_depth(MAX_LEDS);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [lsfs_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            written;
  logic [AW-1:0]               addr;

  assign addr = sreq.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (sreq.wr_en) begin
      mem[addr] <= sreq.wdata;
    end
    if (sreq.rd_en) begin
      rd_data  <= mem[addr];
      rd_valid <= written[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (sreq.clr) begin
      written <= '0;
    end else if (sreq.wr_en) begin
      written[addr] <= 1'b1;
    end
  end

endmodule

### rtl/lsfs_seq.sv
// ----------------------------------------------------------------------------
// lsfs_seq
// Request decode, frame sequencer and output word register.
// ----------------------------------------------------------------------------
module lsfs_seq #(
  parameter int MAX_LEDS = lsfs_pkg::MAX_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lsfs_pkg::CNT_W-1:0]    eff_count,
  lsfs_req_if.sink                      req,
  lsfs_tx_if.source                     tx,
  output lsfs_pkg::store_req_t          sreq,
  input  logic [lsfs_pkg::WORD_W-1:0]   rd_data,
  input  logic                          rd_valid
);

  localparam int DEPTH = lsfs_pkg::store_depth(MAX_LEDS);

  typedef enum logic [1:0] {PH_IDLE, PH_START, PH_LEDS, PH_TAIL} phase_t;
  typedef enum logic [1:0] {SRC_ZERO, SRC_OFF, SRC_STORE} src_t;

  phase_t                         phase;
  logic                           blank_mode;
  logic [1:0]                     byte_in_group;
  logic [lsfs_pkg::CNT_W-1:0]     led_counter;
  logic [lsfs_pkg::CNT_W-1:0]     frame_count;
  logic [lsfs_pkg::TAIL_W-1:0]    tail_left;

  logic                           pend;
  src_t                           p_src;
  logic [1:0]                     p_bsel;
  logic                           p_sb;
  logic                           p_se;
  logic                           p_last;

  logic                           out_valid;
  logic [lsfs_pkg::BYTE_W-1:0]    out_byte;
  logic                           out_sb;
  logic                           out_se;
  logic                           out_last;

  logic                           accept;
  logic                           tick_run;
  logic                           in_store;
  logic [lsfs_pkg::CNT_W-1:0]     cnt_inc;
  logic [lsfs_pkg::BYTE_W-1:0]    bri;
  logic [lsfs_pkg::WORD_W-1:0]    word;
  logic [lsfs_pkg::BYTE_W-1:0]    sel_byte;

  assign req.ready = !pend;
  assign accept    = req.valid && req.ready;
  assign tick_run  = accept && (req.req_type == lsfs_pkg::REQ_TICK) && (phase != PH_IDLE);
  assign in_store  = led_counter < lsfs_pkg::CNT_W'(DEPTH);
  assign cnt_inc   = led_counter + lsfs_pkg::CNT_W'(1);

  assign bri = (req.brightness_in < lsfs_pkg::BRIGHT_MIN)
             ? req.brightness_in + lsfs_pkg::BRIGHT_ADD : req.brightness_in;

  always_comb begin
    sreq.wr_en = accept && (req.req_type == lsfs_pkg::REQ_SET)
               && ({1'b0, req.led_index} < eff_count);
    sreq.clr   = accept && (req.req_type == lsfs_pkg::REQ_CLEAR);
    sreq.rd_en = tick_run && (phase == PH_LEDS) && !blank_mode && in_store;
    sreq.addr  = sreq.rd_en ? led_counter[lsfs_pkg::IDX_W-1:0] : req.led_index;
    sreq.wdata = {bri, req.blue_in, req.green_in, req.red_in};
  end

  always_comb begin
    word = (p_src == SRC_STORE && rd_valid) ? rd_data : lsfs_pkg::OFF_WORD;
    case (p_bsel)
      2'd0:    sel_byte = word[31:24];
      2'd1:    sel_byte = word[23:16];
      2'd2:    sel_byte = word[15:8];
      default: sel_byte = word[7:0];
    endcase
    if (p_src == SRC_ZERO) begin
      sel_byte = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      blank_mode    <= 1'b0;
      byte_in_group <= '0;
      led_counter   <= '0;
      frame_count   <= '0;
      tail_left     <= '0;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // drain the pending byte into the output register
      if (pend && (!out_valid || tx.ready)) begin
        out_valid <= 1'b1;
        out_byte  <= sel_byte;
        out_sb    <= p_sb;
        out_se    <= p_se;
        out_last  <= p_last;
        pend      <= 1'b0;
      end else if (out_valid && tx.ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        case (req.req_type)
          lsfs_pkg::REQ_WRITE, lsfs_pkg::REQ_BLANK: begin
            if (phase == PH_IDLE) begin
              blank_mode    <= (req.req_type == lsfs_pkg::REQ_BLANK);
              frame_count   <= eff_count;
              led_counter   <= '0;
              byte_in_group <= '0;
              tail_left     <= lsfs_pkg::TAIL_W'(eff_count >> 5) + lsfs_pkg::TAIL_W'(2);
              phase         <= PH_START;
            end
          end
          lsfs_pkg::REQ_TICK: begin
            if (phase != PH_IDLE) begin
              pend   <= 1'b1;
              p_bsel <= byte_in_group;
              case (phase)
                PH_START: begin
                  p_src  <= SRC_ZERO;
                  p_sb   <= (byte_in_group == 2'd0);
                  p_se   <= (byte_in_group == 2'd3);
                  p_last <= 1'b0;
                  if (byte_in_group == 2'd3) begin
                    phase <= (frame_count != '0) ? PH_LEDS : PH_TAIL;
                  end
                end
                PH_LEDS: begin
                  p_src  <= (blank_mode || !in_store) ? SRC_OFF : SRC_STORE;
                  p_sb   <= (led_counter == '0) && (byte_in_group == 2'd0);
                  p_se   <= (cnt_inc == frame_count) && (byte_in_group == 2'd3);
                  p_last <= 1'b0;
                  if (byte_in_group == 2'd3) begin
                    led_counter <= cnt_inc;
                    if (cnt_inc >= frame_count) begin
                      phase <= PH_TAIL;
                    end
                  end
                end
                default: begin
                  p_src  <= SRC_ZERO;
                  p_sb   <= (byte_in_group == 2'd0);
                  p_se   <= (byte_in_group == 2'd3);
                  p_last <= (byte_in_group == 2'd3) && (tail_left == lsfs_pkg::TAIL_W'(1));
                  if (byte_in_group == 2'd3) begin
                    tail_left <= tail_left - lsfs_pkg::TAIL_W'(1);
                    if (tail_left == lsfs_pkg::TAIL_W'(1)) begin
                      phase <= PH_IDLE;
                    end
                  end
                end
              endcase
              byte_in_group <= byte_in_group + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign tx.valid        = out_valid;
  assign tx.out_byte     = out_byte;
  assign tx.select_begin = out_sb;
  assign tx.select_end   = out_se;
  assign tx.last         = out_last;

endmodule

### rtl/led_strip_frame_sender.sv
// ----------------------------------------------------------------------------
// led_strip_frame_sender
// Serial LED strip driver: keeps per-LED words and sends frames byte by byte.
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// req      in   valid/ready    req_type, led_index, brightness_in, blue_in,
//                              green_in, red_in
// tx       out  valid/ready    out_byte, select_begin, select_end, last
// cfg      in   cfg_wr_en      cfg_wr_data (led_count)
//
// set, clear and start requests leave req.ready high for the next request
// a tick that yields a word passes through the store read, then the output register
// req.ready drops while a word waits for the output register to free up
// synchronous reset clears the LED count, the sequencer and the written flags, not the memory
// ----------------------------------------------------------------------------
module led_strip_frame_sender #(
  parameter int MAX_LEDS = lsfs_pkg::MAX_LEDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lsfs_pkg::CNT_W-1:0]  cfg_wr_data,
  lsfs_req_if.sink                    req,
  lsfs_tx_if.source                   tx
);

  localparam int CNT_MAX = (1 << lsfs_pkg::CNT_W) - 1;
  localparam int CAP     = (MAX_LEDS > CNT_MAX) ? CNT_MAX : MAX_LEDS;

  logic [lsfs_pkg::CNT_W-1:0]  led_count;
  logic [lsfs_pkg::CNT_W-1:0]  eff_count;
  lsfs_pkg::store_req_t        sreq;
  logic [lsfs_pkg::WORD_W-1:0] rd_data;
  logic                        rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= '0;
    end else if (cfg_wr_en) begin
      led_count <= cfg_wr_data;
    end
  end

  assign eff_count = (led_count > lsfs_pkg::CNT_W'(CAP)) ? lsfs_pkg::CNT_W'(CAP) : led_count;

  lsfs_seq #(.MAX_LEDS(MAX_LEDS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .eff_count (eff_count),
    .req       (req),
    .tx        (tx),
    .sreq      (sreq),
    .rd_data   (rd_data),
    .rd_valid  (rd_valid)
  );

  lsfs_store #(.MAX_LEDS(MAX_LEDS)) u_store (
    .clk      (clk),
    .rst      (rst),
    .sreq     (sreq),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

endmodule

### rtl/lsfs_checker.sv
// ----------------------------------------------------------------------------
// lsfs_checker
// Port-level checks of the LED strip frame sender, bound to the top level.
// ----------------------------------------------------------------------------
module lsfs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [lsfs_pkg::REQ_W-1:0]  in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lsfs_pkg::BYTE_W-1:0] out_byte,
  input logic                        out_last
);

  logic in_acc;
  logic tick_acc;

  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_req_type == lsfs_pkg::REQ_TICK);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  a_word_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tick_acc, 2))
    else $error("output word without a tick two cycles earlier");

  a_other_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_acc && !tick_acc |=> in_ready)
    else $error("non-tick request held off the next request");

endmodule

bind led_strip_frame_sender lsfs_checker u_lsfs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .in_req_type (req.req_type),
  .out_valid   (tx.valid),
  .out_ready   (tx.ready),
  .out_byte    (tx.out_byte),
  .out_last    (tx.last)
);

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: led_strip_frame_sender testbench
// Drives set, clear, write, blank and tick requests with bursty timing and a
// stalling byte sink. A shadow copy of the LED store and of the frame
// sequencer predicts every word on the byte channel. Each word is checked
// field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import lsfs_pkg::*;

  // worst case: the sink hold-off plus random sink stalls
  localparam int QUIET_LIMIT = 4000;
  localparam int FEED_PHASES = 8;
  localparam int PHASE_ITEMS = 12;
  localparam int FILL_LEDS   = 32;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_START, SEQ_LEDS, SEQ_TAIL} seq_phase_t;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] bri;
    logic [BYTE_W-1:0] blu;
    logic [BYTE_W-1:0] grn;
    logic [BYTE_W-1:0] red;
  } strip_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              cs_fall;
    logic              cs_rise;
    logic              fin;
  } strip_byte_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  lsfs_req_if req_if ();
  lsfs_tx_if  tx_if ();

  led_strip_frame_sender dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req(req_if),
    .tx(tx_if)
  );

  always #6 clk = ~clk;

  // shadow of the block
  logic [WORD_W-1:0] shadow_word [MAX_LEDS_DEF];
  bit                shadow_set  [MAX_LEDS_DEF];
  seq_phase_t        seq_phase;
  bit                seq_blank;
  logic [1:0]        seq_byte;
  int unsigned       seq_led;
  int unsigned       seq_leds;
  int unsigned       seq_tail;
  logic [CNT_W-1:0]  strip_len;

  strip_byte_t pending_bytes [$];

  int fail_count;
  int requests_sent;
  int words_checked;
  int frames_done;
  int burst_left;
  bit steady_feed;
  int hold_cycles;
  int quiet;

  function automatic int unsigned live_leds();
    return (strip_len > MAX_LEDS_DEF) ? MAX_LEDS_DEF : strip_len;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic strip_req_t word_req(input logic [REQ_W-1:0] kind,
                                          input logic [7:0] idx, input logic [7:0] bri,
                                          input logic [7:0] blu, input logic [7:0] grn,
                                          input logic [7:0] red);
    strip_req_t r;
    r.kind = kind;
    r.idx  = idx;
    r.bri  = bri;
    r.blu  = blu;
    r.grn  = grn;
    r.red  = red;
    return r;
  endfunction

  function automatic strip_req_t tick_req();
    return word_req(REQ_TICK, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
  endfunction

  function automatic void predict_req(input strip_req_t r);
    strip_byte_t       b;
    logic [BYTE_W-1:0] bri;
    logic [WORD_W-1:0] w;
    int                sh;
    b = '0;
    case (r.kind)
      REQ_SET: begin
        if (r.idx < live_leds()) begin
          bri = (r.bri < BRIGHT_MIN) ? r.bri + BRIGHT_ADD : r.bri;
          shadow_word[r.idx] = {bri, r.blu, r.grn, r.red};
          shadow_set[r.idx] = 1'b1;
        end
      end
      REQ_WRITE, REQ_BLANK: begin
        if (seq_phase == SEQ_IDLE) begin
          seq_blank = (r.kind == REQ_BLANK);
          seq_leds  = live_leds();
          seq_led   = 0;
          seq_byte  = 2'd0;
          seq_tail  = seq_leds / 32 + 2;
          seq_phase = SEQ_START;
        end
      end
      REQ_CLEAR: begin
        foreach (shadow_set[i]) shadow_set[i] = 1'b0;
      end
      REQ_TICK: begin
        if (seq_phase != SEQ_IDLE) begin
          case (seq_phase)
            SEQ_START: begin
              b.cs_fall = (seq_byte == 2'd0);
              b.cs_rise = (seq_byte == 2'd3);
              if (seq_byte == 2'd3) seq_phase = (seq_leds > 0) ? SEQ_LEDS : SEQ_TAIL;
            end
            SEQ_LEDS: begin
              w = (seq_blank || !shadow_set[seq_led]) ? OFF_WORD : shadow_word[seq_led];
              sh = 24 - 8 * int'(seq_byte);
              b.data = w[sh +: 8];
              b.cs_fall = (seq_led == 0 && seq_byte == 2'd0);
              b.cs_rise = (seq_led + 1 == seq_leds && seq_byte == 2'd3);
              if (seq_byte == 2'd3) begin
                seq_led++;
                if (seq_led >= seq_leds) seq_phase = SEQ_TAIL;
              end
            end
            default: begin
              b.cs_fall = (seq_byte == 2'd0);
              b.cs_rise = (seq_byte == 2'd3);
              if (seq_byte == 2'd3) begin
                seq_tail--;
                if (seq_tail == 0) begin
                  b.fin = 1'b1;
                  seq_phase = SEQ_IDLE;
                end
              end
            end
          endcase
          seq_byte = seq_byte + 2'd1;
          pending_bytes.push_back(b);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input strip_req_t r);
    int gap;
    if (!steady_feed && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid         <= 1'b1;
    req_if.req_type      <= r.kind;
    req_if.led_index     <= r.idx;
    req_if.brightness_in <= r.bri;
    req_if.blue_in       <= r.blu;
    req_if.green_in      <= r.grn;
    req_if.red_in        <= r.red;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    predict_req(r);
    requests_sent++;
  endtask

  // run the frame out, then wait for the last word and the pipeline
  task automatic settle();
    while (seq_phase != SEQ_IDLE) send_word(tick_req());
    req_if.valid <= 1'b0;
    wait (pending_bytes.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_strip_len(input logic [CNT_W-1:0] n);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    strip_len = n;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_fill_store();
    set_strip_len(CNT_W'(FILL_LEDS));
    for (int i = 0; i < FILL_LEDS; i++) begin
      send_word(word_req(REQ_SET, 8'(i), (i % 2) ? 8'($urandom_range(0, 31)) : rnd8(),
                         rnd8(), rnd8(), rnd8()));
    end
    send_word(word_req(REQ_WRITE, rnd8(), rnd8(), rnd8(), rnd8(), rnd8()));
    settle();
  endtask

  task automatic test_edge_cases();
    send_word(tick_req());
    for (int k = 5; k < 8; k++) send_word(word_req(REQ_W'(k), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    set_strip_len(9'd0);
    send_word(word_req(REQ_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();
    set_strip_len(9'd3);
    send_word(word_req(REQ_SET, 8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF));
    send_word(word_req(REQ_SET, 8'd1, 8'd31, 8'h00, 8'hFF, 8'h00));
    send_word(word_req(REQ_SET, 8'd2, 8'd32, 8'h5A, 8'hA5, 8'h3C));
    send_word(word_req(REQ_SET, 8'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(word_req(REQ_SET, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(word_req(REQ_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (5) send_word(tick_req());
    // start while running, then a late update of an entry not yet sent
    send_word(word_req(REQ_BLANK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(word_req(REQ_SET, 8'd2, 8'd255, 8'h01, 8'h02, 8'h03));
    repeat (6) send_word(tick_req());
    send_word(word_req(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();
    send_word(word_req(REQ_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(word_req(REQ_BLANK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();
  endtask

  task automatic test_backpressure();
    set_strip_len(9'd8);
    steady_feed = 1'b1;
    send_word(word_req(REQ_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (3) send_word(tick_req());
    hold_cycles = 300;
    repeat (40) send_word(tick_req());
    steady_feed = 1'b0;
    settle();
  endtask

  task automatic test_random_frames();
    logic [CNT_W-1:0]  len_plan [FEED_PHASES];
    int unsigned       live;
    int                pick;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] bri;
    len_plan = '{9'd1, 9'd0, 9'd2, 9'd7, 9'd5, 9'd3, 9'd4, 9'd12};
    for (int p = 0; p < FEED_PHASES; p++) begin
      set_strip_len(len_plan[p]);
      steady_feed = ($urandom_range(0, 3) == 0);
      live = live_leds();
      send_word(word_req(REQ_WRITE, rnd8(), rnd8(), rnd8(), rnd8(), rnd8()));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
          idx = (live == 0 || $urandom_range(0, 7) == 0) ? rnd8()
                                                          : 8'($urandom_range(0, live - 1));
          bri = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 31)) : rnd8();
          send_word(word_req(REQ_SET, idx, bri, rnd8(), rnd8(), rnd8()));
        end else if (pick < 28) begin
          send_word(word_req(REQ_WRITE, rnd8(), rnd8(), rnd8(), rnd8(), rnd8()));
        end else if (pick < 31) begin
          send_word(word_req(REQ_BLANK, rnd8(), rnd8(), rnd8(), rnd8(), rnd8()));
        end else if (pick < 33) begin
          send_word(word_req(REQ_CLEAR, rnd8(), rnd8(), rnd8(), rnd8(), rnd8()));
        end else if (pick < 35) begin
          send_word(word_req(REQ_W'($urandom_range(5, 7)), rnd8(), rnd8(), rnd8(), rnd8(),
                             rnd8()));
        end else begin
          send_word(tick_req());
        end
      end
      steady_feed = 1'b0;
    end
    settle();
  endtask

  // byte sink
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    tx_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_left = hold_cycles;
        hold_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: tx_if.ready <= 1'b1;
          1: tx_if.ready <= ($urandom_range(0, 1) == 1);
          2: tx_if.ready <= ($urandom_range(0, 3) == 0);
          default: tx_if.ready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    strip_byte_t want;
    if (!rst && tx_if.valid === 1'b1 && tx_if.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word: expected none, got byte %02h", $time, tx_if.out_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (tx_if.out_byte !== want.data) begin
          fail_count++;
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, tx_if.out_byte);
        end
        if (tx_if.select_begin !== want.cs_fall) begin
          fail_count++;
          $display("%0t: select_begin expected %0b got %0b", $time, want.cs_fall,
                   tx_if.select_begin);
        end
        if (tx_if.select_end !== want.cs_rise) begin
          fail_count++;
          $display("%0t: select_end expected %0b got %0b", $time, want.cs_rise,
                   tx_if.select_end);
        end
        if (tx_if.last !== want.fin) begin
          fail_count++;
          $display("%0t: last expected %0b got %0b", $time, want.fin, tx_if.last);
        end
        words_checked++;
        if (want.fin) frames_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (tx_if.valid === 1'b1 && tx_if.ready === 1'b1)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("[led_strip_frame_sender] ERROR");
      $finish;
    end
  end

  initial begin
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_SET;
    req_if.led_index     <= '0;
    req_if.brightness_in <= '0;
    req_if.blue_in       <= '0;
    req_if.green_in      <= '0;
    req_if.red_in        <= '0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    quiet = 0;
    fail_count = 0;
    requests_sent = 0;
    words_checked = 0;
    frames_done = 0;
    burst_left = 0;
    steady_feed = 1'b0;
    hold_cycles = 0;
    strip_len = '0;
    seq_phase = SEQ_IDLE;
    seq_blank = 1'b0;
    seq_byte = 2'd0;
    seq_led = 0;
    seq_leds = 0;
    seq_tail = 0;
    foreach (shadow_set[i]) shadow_set[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_store();
    test_edge_cases();
    test_backpressure();
    test_random_frames();

    settle();
    repeat (16) @(posedge clk);
    $display("covered %0d requests and %0d checked words in %0d frames,", requests_sent,
             words_checked, frames_done);
    $display("strip lengths 0 to 32, sink hold-off and bursty feed");
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("[led_strip_frame_sender] OK");
    end else begin
      $display("[led_strip_frame_sender] ERROR");
    end
    $finish;
  end

endmodule
